// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/adl_pkg.sv =====
package adl_pkg;

  localparam int FEAT_W  = 16;   // Q4.12 feature
  localparam int W_W     = 32;   // Q16.16 weight and sum
  localparam int PROD_W  = 48;   // weight times feature, Q.28
  localparam int ACC_W   = 52;   // sum of up to nine products
  localparam int FRAC_X  = 12;   // fraction bits of a feature
  localparam int FRAC_R  = 16;   // fraction bits of the learning rate
  localparam int CLIP_W  = ACC_W - FRAC_X;  // pre-saturation width
  localparam int ERR_W   = 34;
  localparam int GRAD_W  = 34;
  localparam int GPROD_W = ERR_W + 17;      // rate (unsigned, 17 bits signed) times error
  localparam int GX_W    = GRAD_W + FEAT_W; // gradient times feature
  localparam int STEP_W  = GX_W - FRAC_X;

  localparam int TGT_W   = 8;
  localparam int RATE_W  = 16;
  localparam int LANES_W = 4;
  localparam int WIDX_W  = 4;

  typedef logic signed [FEAT_W-1:0]  feat_t;
  typedef logic signed [W_W-1:0]     weight_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [CLIP_W-1:0]  clip_t;
  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic signed [GRAD_W-1:0]  grad_t;
  typedef logic signed [STEP_W-1:0]  step_t;

  // The bias lane sees a constant input of 1.0 in Q4.12.
  localparam feat_t FEAT_ONE = 16'sh1000;

  localparam logic [RATE_W-1:0]  RATE_RESET  = 16'd655;
  localparam logic [LANES_W-1:0] LANES_RESET = 4'd8;

  typedef enum logic [1:0] {
    CMD_COMPUTE = 2'd0,
    CMD_TRAIN   = 2'd1,
    CMD_WRITE   = 2'd2
  } cmd_t;

  typedef enum logic {
    CFG_LEARNING_RATE = 1'b0,
    CFG_INPUTS_IN_USE = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_MUL  = 3'd1,
    S_SUM  = 3'd2,
    S_GRAD = 3'd3,
    S_UPD  = 3'd4,
    S_OUT  = 3'd5
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic upd_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic sum_en;
    logic grad_en;
  } merge_ctrl_t;

  // True when v does not fit the signed 32-bit weight range.
  function automatic logic clips_w(input clip_t v);
    logic [CLIP_W-W_W:0] top;
    top = v[CLIP_W-1:W_W-1];
    return !((&top) || (~|top));
  endfunction

  function automatic weight_t sat_w(input clip_t v);
    weight_t res;
    if (clips_w(v)) begin
      res = v[CLIP_W-1] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
    end else begin
      res = v[W_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/adl_lane.sv =====
module adl_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  adl_pkg::lane_ctrl_t ctrl,
  input  logic              wr_en,
  input  logic              active,
  input  adl_pkg::feat_t    feature,
  input  adl_pkg::weight_t  wr_value,
  input  adl_pkg::grad_t    grad,
  output adl_pkg::prod_t    product_r,
  output logic              upd_clip
);
  import adl_pkg::*;

  weight_t weight_r;
  weight_t weight_nxt;
  prod_t   prod_nxt;
  logic signed [GX_W-1:0] gx;
  step_t   step;
  clip_t   diff;

  always_comb begin
    prod_nxt   = weight_r * feature;
    gx         = grad * feature;
    step       = gx[GX_W-1:FRAC_X];
    diff       = clip_t'(weight_r) - clip_t'(step);
    weight_nxt = sat_w(diff);
    upd_clip   = ctrl.upd_en && active && clips_w(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= '0;
    end else if (wr_en) begin
      weight_r <= wr_value;
    end else if (ctrl.upd_en && active) begin
      weight_r <= weight_nxt;
    end
  end

  // A lane outside the configured count contributes nothing to the sum.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      product_r <= active ? prod_nxt : '0;
    end
  end

endmodule

// ===== rtl/adl_merge.sv =====
module adl_merge #(
  parameter int NUM_LANES = 9
) (
  input  logic                          clk,
  input  adl_pkg::merge_ctrl_t          ctrl,
  input  adl_pkg::prod_t                products [NUM_LANES],
  input  logic [adl_pkg::RATE_W-1:0]    learning_rate,
  input  logic signed [adl_pkg::TGT_W-1:0] target,
  output adl_pkg::weight_t              sum_r,
  output logic                          sum_clip_r,
  output adl_pkg::grad_t                grad_r
);
  import adl_pkg::*;

  acc_t  acc;
  clip_t scaled;
  err_t  err;
  logic signed [GPROD_W-1:0] gprod;

  always_comb begin
    acc = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      acc = acc + acc_t'(products[k]);
    end
    scaled = acc[ACC_W-1:FRAC_X];
    // The error uses the saturated sum, as the output does.
    err   = err_t'(sum_r) - (err_t'(target) <<< FRAC_R);
    gprod = $signed({1'b0, learning_rate}) * err;
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      sum_r      <= sat_w(scaled);
      sum_clip_r <= clips_w(scaled);
    end
    if (ctrl.grad_en) begin
      grad_r <= gprod[GRAD_W+FRAC_R-1:FRAC_R];
    end
  end

endmodule

// ===== rtl/adaline_lms_neuron_update.sv =====
// Channel  Handshake              Payload
// in       in_valid / in_ready    command, target, weight index/value, eight features
// out      out_valid / out_ready  neuron_output, saturated
// cfg      cfg_valid / cfg_ready  cfg_index (0 rate, 1 lane count), cfg_data
//
// One item at a time: a compute item passes the multiply stage and the merge sum, a
// train item also the gradient and the weight update in every lane, all in turn;
// write and unknown commands go straight to the output register. A new item can be
// taken from the cycle after the result loads.
// Synchronous active-low reset clears all weights and loads the register defaults.
// The output register holds a result while out_ready is low; the next item is
// taken meanwhile and waits in its last stage until the register frees.
`include "assert_macros.svh"

module adaline_lms_neuron_update #(
  parameter int MAX_INPUTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic signed [7:0]  in_target,
  input  logic [3:0]  in_weight_index,
  input  logic signed [31:0] in_weight_value,
  input  logic signed [15:0] in_feature_0,
  input  logic signed [15:0] in_feature_1,
  input  logic signed [15:0] in_feature_2,
  input  logic signed [15:0] in_feature_3,
  input  logic signed [15:0] in_feature_4,
  input  logic signed [15:0] in_feature_5,
  input  logic signed [15:0] in_feature_6,
  input  logic signed [15:0] in_feature_7,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_neuron_output,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import adl_pkg::*;

  localparam int NUM_LANES = MAX_INPUTS + 1;

  state_t      state_r, state_nxt;
  lane_ctrl_t  lane_ctrl;
  merge_ctrl_t merge_ctrl;
  logic        out_load;
  logic        in_accept;
  logic        is_calc;

  logic [1:0]  cmd_r;
  logic signed [TGT_W-1:0] tgt_r;
  feat_t       in_feat [8];
  feat_t       feat_r [MAX_INPUTS];
  feat_t       lane_feat [NUM_LANES];
  prod_t       products [NUM_LANES];
  logic [NUM_LANES-1:0] lane_clip;
  logic [NUM_LANES-1:0] lane_wr;
  logic [NUM_LANES-1:0] lane_active;
  logic        upd_clip_r;

  logic [RATE_W-1:0]  rate_r;
  logic [LANES_W-1:0] lanes_r;

  weight_t     sum;
  logic        sum_clip;
  grad_t       grad;

  logic        out_valid_r;
  weight_t     out_data_r;
  logic        out_sat_r;

  assign in_feat[0] = in_feature_0;
  assign in_feat[1] = in_feature_1;
  assign in_feat[2] = in_feature_2;
  assign in_feat[3] = in_feature_3;
  assign in_feat[4] = in_feature_4;
  assign in_feat[5] = in_feature_5;
  assign in_feat[6] = in_feature_6;
  assign in_feat[7] = in_feature_7;

  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign is_calc   = (cmd_r == CMD_COMPUTE) || (cmd_r == CMD_TRAIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= RATE_RESET;
      lanes_r <= LANES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEARNING_RATE: rate_r  <= cfg_data;
        CFG_INPUTS_IN_USE: lanes_r <= cfg_data[LANES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    lane_ctrl  = '0;
    merge_ctrl = '0;
    out_load   = 1'b0;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command == CMD_COMPUTE || in_command == CMD_TRAIN) begin
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_MUL: begin
        lane_ctrl.mul_en = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        merge_ctrl.sum_en = 1'b1;
        state_nxt = (cmd_r == CMD_TRAIN) ? S_GRAD : S_OUT;
      end
      S_GRAD: begin
        merge_ctrl.grad_en = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        lane_ctrl.upd_en = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r <= in_command;
      tgt_r <= in_target;
      for (int i = 0; i < MAX_INPUTS; i++) begin
        feat_r[i] <= in_feat[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_clip_r <= 1'b0;
    end else if (in_accept) begin
      upd_clip_r <= 1'b0;
    end else if (lane_ctrl.upd_en) begin
      upd_clip_r <= |lane_clip;
    end
  end

  // Lane 0 carries the bias with a constant input of one.
  always_comb begin
    lane_feat[0]   = FEAT_ONE;
    lane_active[0] = 1'b1;
    for (int k = 1; k < NUM_LANES; k++) begin
      lane_feat[k]   = feat_r[k-1];
      lane_active[k] = (LANES_W'(k) <= lanes_r);
    end
    for (int k = 0; k < NUM_LANES; k++) begin
      lane_wr[k] = in_accept && (in_command == CMD_WRITE) &&
                   (in_weight_index == WIDX_W'(k));
    end
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    adl_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (lane_ctrl),
      .wr_en     (lane_wr[k]),
      .active    (lane_active[k]),
      .feature   (lane_feat[k]),
      .wr_value  (in_weight_value),
      .grad      (grad),
      .product_r (products[k]),
      .upd_clip  (lane_clip[k])
    );
  end

  adl_merge #(
    .NUM_LANES (NUM_LANES)
  ) u_merge (
    .clk           (clk),
    .ctrl          (merge_ctrl),
    .products      (products),
    .learning_rate (rate_r),
    .target        (tgt_r),
    .sum_r         (sum),
    .sum_clip_r    (sum_clip),
    .grad_r        (grad)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= is_calc ? sum : '0;
      out_sat_r  <= is_calc && (sum_clip || upd_clip_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_neuron_output = out_data_r;
  assign out_saturated     = out_sat_r;

  `ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, in_accept, state_r != S_IDLE,
              "accepted item did not start processing")
  `ASSERT_IMP(a_update_only_train, clk, rst_n, state_r == S_UPD, cmd_r == CMD_TRAIN,
              "weight update for an item that is not a train command")
  `ASSERT_NXT(a_grad_then_update, clk, rst_n, state_r == S_GRAD, state_r == S_UPD,
              "gradient stage not followed by weight update")
  `ASSERT_IMP(a_load_when_free, clk, rst_n, out_load, !out_valid_r || out_ready,
              "result overwrote an item not yet taken")

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import adl_pkg::*;

  localparam int LANES = 8;
  localparam logic [1:0] CMD_UNDEFINED = 2'd3;
  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
  localparam longint W_HI = 64'sd2147483647;
  localparam longint W_LO = -W_HI - 1;

  typedef struct packed {
    logic [1:0]        command;
    logic [7:0]        target;
    logic [3:0]        weight_index;
    logic [31:0]       weight_value;
    logic [7:0][15:0]  feature;
  } sample_t;

  typedef struct packed {
    logic [31:0] neuron_output;
    logic        saturated;
  } neuron_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = '0;
  logic signed [7:0] in_target = '0;
  logic [3:0] in_weight_index = '0;
  logic signed [31:0] in_weight_value = '0;
  logic signed [15:0] in_feature_0 = '0, in_feature_1 = '0, in_feature_2 = '0;
  logic signed [15:0] in_feature_3 = '0, in_feature_4 = '0, in_feature_5 = '0;
  logic signed [15:0] in_feature_6 = '0, in_feature_7 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_neuron_output;
  logic out_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  // Shadow copy of the neuron state and its registers.
  longint weight_mirror [0:LANES];
  logic [15:0] rate_q16 = RATE_RESET;
  logic [3:0] lane_count = LANES_RESET;

  neuron_result_t expected_results [$];
  neuron_result_t head;
  int mismatches = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_run = 0;

  adaline_lms_neuron_update #(.MAX_INPUTS(LANES)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_target(in_target),
    .in_weight_index(in_weight_index), .in_weight_value(in_weight_value),
    .in_feature_0(in_feature_0), .in_feature_1(in_feature_1),
    .in_feature_2(in_feature_2), .in_feature_3(in_feature_3),
    .in_feature_4(in_feature_4), .in_feature_5(in_feature_5),
    .in_feature_6(in_feature_6), .in_feature_7(in_feature_7),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_neuron_output(out_neuron_output), .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bit out_of_range(input longint v);
    return (v > W_HI) || (v < W_LO);
  endfunction

  function automatic longint clamp_w(input longint v);
    return (v > W_HI) ? W_HI : ((v < W_LO) ? W_LO : v);
  endfunction

  // Computes the result of one item and applies any weight change it makes.
  function automatic neuron_result_t predict_neuron(input sample_t s);
    neuron_result_t r;
    longint x [LANES];
    longint acc, raw, sum, err, grad, delta;
    int used;
    logic clipped;
    r = '0;
    clipped = 1'b0;
    case (s.command)
      CMD_WRITE: begin
        if (s.weight_index <= LANES) weight_mirror[s.weight_index] = $signed(s.weight_value);
      end
      CMD_COMPUTE, CMD_TRAIN: begin
        used = (lane_count > LANES) ? LANES : lane_count;
        for (int i = 0; i < LANES; i++) x[i] = $signed(s.feature[i]);
        acc = weight_mirror[0] <<< FRAC_X;
        for (int i = 0; i < used; i++) acc += weight_mirror[i + 1] * x[i];
        raw = acc >>> FRAC_X;
        clipped = out_of_range(raw);
        sum = clamp_w(raw);
        if (s.command == CMD_TRAIN) begin
          err = sum - (longint'($signed(s.target)) <<< FRAC_R);
          grad = (longint'(rate_q16) * err) >>> FRAC_R;
          raw = weight_mirror[0] - grad;
          clipped |= out_of_range(raw);
          weight_mirror[0] = clamp_w(raw);
          for (int i = 0; i < used; i++) begin
            delta = (grad * x[i]) >>> FRAC_X;
            raw = weight_mirror[i + 1] - delta;
            clipped |= out_of_range(raw);
            weight_mirror[i + 1] = clamp_w(raw);
          end
        end
        r.neuron_output = sum[31:0];
        r.saturated = clipped;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic log_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        log_mismatch("result with nothing pending", 0, out_neuron_output);
      end else begin
        head = expected_results.pop_front();
        if (head.neuron_output !== out_neuron_output)
          log_mismatch("neuron_output", $signed(head.neuron_output), out_neuron_output);
        if (head.saturated !== out_saturated)
          log_mismatch("saturated", head.saturated, out_saturated);
      end
    end
  end

  // Result side: a forced hold-off takes priority over random stalls.
  always @(negedge clk) begin
    if (stall_run > 0) begin
      out_ready <= 1'b0;
      stall_run <= stall_run - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input sample_t s);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= s.command;
    in_target <= s.target;
    in_weight_index <= s.weight_index;
    in_weight_value <= s.weight_value;
    in_feature_0 <= s.feature[0];
    in_feature_1 <= s.feature[1];
    in_feature_2 <= s.feature[2];
    in_feature_3 <= s.feature[3];
    in_feature_4 <= s.feature[4];
    in_feature_5 <= s.feature[5];
    in_feature_6 <= s.feature[6];
    in_feature_7 <= s.feature[7];
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_neuron(s));
  endtask

  // Stops offering items and waits until every pending result has come back, or until its wait limit runs out.
  task automatic drain();
    int n;
    @(negedge clk);
    in_valid <= 1'b0;
    for (n = 0; n < 20000 && expected_results.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [15:0] data);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_LEARNING_RATE) rate_q16 = data;
    else lane_count = data[3:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int sender_pct, input int recv_pct);
    sender_idle_pct = sender_pct;
    recv_stall_pct = recv_pct;
  endtask

  function automatic sample_t make_sample(input logic [1:0] cmd, input logic [7:0] tgt,
                                          input logic [3:0] idx, input logic [31:0] val,
                                          input logic [15:0] fill);
    sample_t s;
    s.command = cmd;
    s.target = tgt;
    s.weight_index = idx;
    s.weight_value = val;
    for (int i = 0; i < LANES; i++) s.feature[i] = fill;
    return s;
  endfunction

  function automatic logic [15:0] rand_feature();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 16383) - 8192);
  endfunction

  function automatic logic [31:0] small_weight();
    return $urandom_range(0, 262143) - 131072;
  endfunction

  // Mostly training and inference on moderate values, with some raw noise.
  function automatic sample_t rand_sample();
    sample_t s;
    int roll;
    roll = $urandom_range(0, 99);
    s.command = (roll < 45) ? CMD_TRAIN : (roll < 80) ? CMD_COMPUTE :
                (roll < 95) ? CMD_WRITE : CMD_UNDEFINED;
    if ($urandom_range(0, 4) == 0) s.target = 8'($urandom);
    else s.target = $urandom_range(0, 1) ? 8'sd1 : -8'sd1;
    s.weight_index = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) :
                     4'($urandom_range(0, 8));
    s.weight_value = ($urandom_range(0, 3) == 0) ? $urandom : small_weight();
    for (int i = 0; i < LANES; i++) s.feature[i] = rand_feature();
    return s;
  endfunction

  task automatic test_reset_state();
    send_item(make_sample(CMD_COMPUTE, 8'sd1, 4'd0, 32'd0, 16'h7FFF));
    drain();
  endtask

  task automatic test_weight_load();
    sample_t s;
    send_item(make_sample(CMD_WRITE, 8'sd0, 4'd0, ONE_Q16, 16'h0000));
    send_item(make_sample(CMD_WRITE, 8'sd0, 4'd1, 32'h8000_0000, 16'hFFFF));
    send_item(make_sample(CMD_WRITE, 8'sd0, 4'd8, 32'h7FFF_FFFF, 16'h0000));
    // Indexes past the last lane must leave every weight alone.
    send_item(make_sample(CMD_WRITE, 8'sd0, 4'd9, 32'h1234_5678, 16'h0000));
    send_item(make_sample(CMD_WRITE, 8'sd0, 4'd15, 32'hFFFF_FFFF, 16'h0000));
    send_item(make_sample(CMD_UNDEFINED, 8'sh7F, 4'd0, 32'h7FFF_FFFF, 16'h7FFF));
    s = make_sample(CMD_COMPUTE, 8'sd0, 4'd0, 32'd0, 16'h0000);
    s.feature[0] = FEAT_ONE;
    send_item(s);
    drain();
  endtask

  task automatic test_sum_saturation();
    sample_t s;
    s = make_sample(CMD_COMPUTE, 8'sd0, 4'd0, 32'd0, 16'h0000);
    s.feature[7] = 16'h7FFF;
    send_item(s);
    s = make_sample(CMD_COMPUTE, 8'sd0, 4'd0, 32'd0, 16'h0000);
    s.feature[0] = 16'h7FFF;
    send_item(s);
    send_item(make_sample(CMD_COMPUTE, 8'sd0, 4'd0, 32'd0, 16'h8000));
    drain();
  endtask

  task automatic test_training();
    sample_t s;
    s = make_sample(CMD_TRAIN, 8'sd1, 4'd0, 32'd0, 16'h0000);
    s.feature[0] = FEAT_ONE;
    send_item(s);
    cfg_write(CFG_LEARNING_RATE, 16'hFFFF);
    send_item(make_sample(CMD_TRAIN, 8'sh80, 4'd0, 32'd0, 16'h8000));
    send_item(make_sample(CMD_TRAIN, 8'sh7F, 4'd0, 32'd0, 16'h7FFF));
    cfg_write(CFG_LEARNING_RATE, 16'h0000);
    send_item(make_sample(CMD_TRAIN, 8'sh55, 4'd0, 32'd0, 16'h2AAA));
    cfg_write(CFG_LEARNING_RATE, RATE_RESET);
  endtask

  task automatic test_lane_counts();
    cfg_write(CFG_INPUTS_IN_USE, 16'h0000);
    send_item(make_sample(CMD_COMPUTE, 8'sd0, 4'd0, 32'd0, 16'h7FFF));
    cfg_write(CFG_INPUTS_IN_USE, 16'h0001);
    send_item(make_sample(CMD_TRAIN, -8'sd1, 4'd0, 32'd0, FEAT_ONE));
    // A lane count above the number of lanes is taken as all lanes.
    cfg_write(CFG_INPUTS_IN_USE, 16'hFFFF);
    send_item(make_sample(CMD_COMPUTE, 8'sd0, 4'd0, 32'd0, FEAT_ONE));
    cfg_write(CFG_INPUTS_IN_USE, 16'h0008);
  endtask

  task automatic test_backpressure();
    drain();
    set_idling(0, 0);
    @(posedge clk);
    stall_run = 200;
    repeat (12) send_item(rand_sample());
    drain();
  endtask

  task automatic test_random_traffic();
    logic [15:0] rate_sel;
    logic [3:0] lanes_sel;
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: set_idling(0, 0);
        1: set_idling(45, 0);
        2: set_idling(0, 45);
        default: set_idling(6, 6);
      endcase
      rate_sel = (p == 0) ? RATE_RESET : (p == 1) ? 16'hFFFF : (p == 2) ? 16'h0000 :
                 16'($urandom);
      lanes_sel = (p == 3) ? 4'd0 : (p == 5) ? 4'd15 : (p == 0) ? 4'd8 :
                  4'($urandom_range(1, 8));
      cfg_write(CFG_LEARNING_RATE, rate_sel);
      cfg_write(CFG_INPUTS_IN_USE, {12'($urandom), lanes_sel});
      for (int i = 0; i <= LANES; i++)
        send_item(make_sample(CMD_WRITE, 8'($urandom), 4'(i), small_weight(),
                              rand_feature()));
      repeat (47) send_item(rand_sample());
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i <= LANES; i++) weight_mirror[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_weight_load();
    test_sum_saturation();
    test_training();
    test_lane_counts();
    test_backpressure();
    test_random_traffic();
    drain();
    if (expected_results.size() != 0)
      log_mismatch("results still pending at end", 0, expected_results.size());
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/adl_pkg.sv
rtl/adl_lane.sv
rtl/adl_merge.sv
rtl/adaline_lms_neuron_update.sv
verif/tb_top.sv
